[sv/tournament_branch_predictor_macros.svh]
// Assertion helpers for the checker file.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH

// Check a clocked property, disabled while reset is asserted.
`define TBP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a stalled beat keeps valid high and its payload unchanged.
`define TBP_ASSERT_HOLD(label, clk, rst_n, vld, rdy, data, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> (vld && $stable(data))) else $error(msg);

`endif

[sv/tbp_pkg.sv]
package tbp_pkg;

    // Table geometry; TABLE_ENTRIES must be a power of two
    localparam int TABLE_ENTRIES = 2048;
    localparam int HISTORY_BITS  = 11;
    localparam int INDEX_BITS    = $clog2(TABLE_ENTRIES);
    localparam int IDX_HIST_W    = (HISTORY_BITS > INDEX_BITS) ? HISTORY_BITS : INDEX_BITS;

    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 32;
    localparam int CTR_W   = 2;

    // Counter values
    localparam logic [CTR_W-1:0] CTR_MIN           = 2'd0;
    localparam logic [CTR_W-1:0] CTR_MAX           = 2'd3;
    localparam logic [CTR_W-1:0] CTR_STRONG_TAKEN  = 2'd3;
    localparam logic [CTR_W-1:0] CTR_PREFER_GSHARE = 2'd0;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [ADDR_W-1:0] branch_address;
        logic              actual_taken;
    } branch_t;

    typedef struct packed {
        logic               predicted_taken;
        logic               prediction_correct;
        logic               used_bimodal;
        logic [COUNT_W-1:0] correct_count;
    } result_t;

endpackage

[sv/tournament_branch_predictor.sv]
// Tournament branch predictor (gshare plus bimodal with a per-address chooser). One resolved
// branch beat is taken per cycle while branch_ready is high. An accepted beat loads the table
// read register and then, once the result register is free or result_ready is high, the
// result register, which drives the result beat. A new branch follows every cycle while
// result_ready is high. The rate is set by the tables: each is one memory read and written
// once per cycle, with the last update forwarded to a following branch at the same index.
// After reset a clearing pass writes the reset values into all TABLE_ENTRIES entries of the
// tables, one entry per cycle; branch_ready stays low during that pass.
module tournament_branch_predictor (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              branch_valid,
    output logic              branch_ready,
    input  tbp_pkg::branch_t  branch,
    output logic              result_valid,
    input  logic              result_ready,
    output tbp_pkg::result_t  result
);

    localparam int IW = tbp_pkg::INDEX_BITS;
    localparam int CW = tbp_pkg::CTR_W;

    // Two-bit saturating counter update
    function automatic logic [CW-1:0] train(input logic [CW-1:0] c, input logic up);
        logic [CW-1:0] r;
        r = c;
        if (up)
        begin
            if (c != tbp_pkg::CTR_MAX)
                r = c + CW'(1);
        end
        else
        begin
            if (c != tbp_pkg::CTR_MIN)
                r = c - CW'(1);
        end
        return r;
    endfunction

    // Tables: gshare alone, bimodal and chooser share an index
    logic [CW-1:0]   g_mem  [tbp_pkg::TABLE_ENTRIES];
    logic [2*CW-1:0] bc_mem [tbp_pkg::TABLE_ENTRIES];

    logic                            clear_active_reg;
    logic [IW-1:0]                   clear_idx_reg;
    logic [tbp_pkg::HISTORY_BITS-1:0] history_reg;

    logic          s1_valid_reg;
    logic [IW-1:0] s1_idx_b_reg;
    logic [IW-1:0] s1_idx_g_reg;
    logic          s1_taken_reg;
    logic [CW-1:0]   g_rd_reg;
    logic [2*CW-1:0] bc_rd_reg;

    logic [tbp_pkg::COUNT_W-1:0] total_reg;
    logic [tbp_pkg::COUNT_W-1:0] total_next;
    logic                        out_valid_reg;
    tbp_pkg::result_t            out_reg;
    tbp_pkg::result_t            out_next;

    logic                          branch_fire;
    logic                          s1_fire;
    logic [IW-1:0]                 in_idx_b;
    logic [IW-1:0]                 in_idx_g;
    logic [tbp_pkg::IDX_HIST_W-1:0] hist_ext;

    logic [CW-1:0] g_cnt, b_cnt, ch_cnt;
    logic [CW-1:0] g_new, b_new, ch_new;
    logic          g_pred, b_pred, g_ok, b_ok, use_b, pred, ok;

    logic            tbl_we;
    logic [IW-1:0]   g_waddr;
    logic [IW-1:0]   bc_waddr;
    logic [CW-1:0]   g_wdata;
    logic [2*CW-1:0] bc_wdata;

    // Handshake
    assign s1_fire      = s1_valid_reg && (!out_valid_reg || result_ready);
    assign branch_ready = !clear_active_reg && (!s1_valid_reg || s1_fire);
    assign branch_fire  = branch_valid && branch_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Form table indexes from the address and the history before this branch
    assign in_idx_b = branch.branch_address[IW-1:0];
    assign hist_ext = tbp_pkg::IDX_HIST_W'(history_reg);
    assign in_idx_g = in_idx_b ^ hist_ext[IW-1:0];

    // Predict, select and train
    always_comb
    begin
        g_cnt  = g_rd_reg;
        b_cnt  = bc_rd_reg[2*CW-1:CW];
        ch_cnt = bc_rd_reg[CW-1:0];
        g_pred = g_cnt[CW-1];
        b_pred = b_cnt[CW-1];
        use_b  = ch_cnt[CW-1];
        g_ok   = (g_pred == s1_taken_reg);
        b_ok   = (b_pred == s1_taken_reg);
        pred   = use_b ? b_pred : g_pred;
        ok     = (pred == s1_taken_reg);
        g_new  = train(g_cnt, s1_taken_reg);
        b_new  = train(b_cnt, s1_taken_reg);
        if (g_ok && !b_ok)
            ch_new = train(ch_cnt, 1'b0);
        else if (!g_ok && b_ok)
            ch_new = train(ch_cnt, 1'b1);
        else
            ch_new = ch_cnt;

        if (ok && (total_reg != tbp_pkg::COUNT_MAX))
            total_next = total_reg + tbp_pkg::COUNT_W'(1);
        else
            total_next = total_reg;

        out_next.predicted_taken    = pred;
        out_next.prediction_correct = ok;
        out_next.used_bimodal       = use_b;
        out_next.correct_count      = total_next;
    end

    // Pick the table write: clearing pass or a retiring branch
    always_comb
    begin
        tbl_we = clear_active_reg || s1_fire;
        if (clear_active_reg)
        begin
            g_waddr  = clear_idx_reg;
            bc_waddr = clear_idx_reg;
            g_wdata  = tbp_pkg::CTR_STRONG_TAKEN;
            bc_wdata = {tbp_pkg::CTR_STRONG_TAKEN, tbp_pkg::CTR_PREFER_GSHARE};
        end
        else
        begin
            g_waddr  = s1_idx_g_reg;
            bc_waddr = s1_idx_b_reg;
            g_wdata  = g_new;
            bc_wdata = {b_new, ch_new};
        end
    end

    // Write tables; read on accept, forward the update retiring at the same edge
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            g_mem[g_waddr]   <= g_wdata;
            bc_mem[bc_waddr] <= bc_wdata;
        end
        if (branch_fire)
        begin
            if (s1_fire && (in_idx_g == s1_idx_g_reg))
                g_rd_reg <= g_new;
            else
                g_rd_reg <= g_mem[in_idx_g];
            if (s1_fire && (in_idx_b == s1_idx_b_reg))
                bc_rd_reg <= {b_new, ch_new};
            else
                bc_rd_reg <= bc_mem[in_idx_b];
        end
    end

    // Sweep the tables after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_idx_reg    <= '0;
        end
        else if (clear_active_reg)
        begin
            if (clear_idx_reg == IW'(tbp_pkg::TABLE_ENTRIES - 1))
                clear_active_reg <= 1'b0;
            clear_idx_reg <= clear_idx_reg + IW'(1);
        end
    end

    // Control state: history, stage valids, running count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            if (branch_fire)
                history_reg <= tbp_pkg::HISTORY_BITS'({history_reg, branch.actual_taken});

            if (branch_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;

            if (s1_fire)
                total_reg <= total_next;
        end
    end

    // Hold the accepted beat and the result payload
    always_ff @(posedge clk)
    begin
        if (branch_fire)
        begin
            s1_idx_b_reg <= in_idx_b;
            s1_idx_g_reg <= in_idx_g;
            s1_taken_reg <= branch.actual_taken;
        end
        if (s1_fire)
            out_reg <= out_next;
    end

endmodule

[sv/tbp_checker.sv]
`include "tournament_branch_predictor_macros.svh"

module tbp_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             branch_valid,
    input logic             branch_ready,
    input tbp_pkg::branch_t branch,
    input logic             result_valid,
    input logic             result_ready,
    input tbp_pkg::result_t result
);

    // Hold a stalled result beat
    `TBP_ASSERT_HOLD(a_result_hold, clk, rst_n, result_valid, result_ready, result,
        "result beat changed while stalled")

    // A rising result valid must be preceded by an accepted branch beat
    `TBP_ASSERT(a_result_follows_branch, clk, rst_n,
        $rose(result_valid) |-> $past(branch_valid && branch_ready, 2),
        "result without a preceding branch beat")

    // A correct prediction is counted unless the count is saturated, so its count is never zero
    `TBP_ASSERT(a_count_nonzero, clk, rst_n,
        (result_valid && result.prediction_correct) |-> (result.correct_count != '0),
        "correct prediction with zero count")

    // A wrong prediction leaves the count where the previous result left it
    `TBP_ASSERT(a_count_steady, clk, rst_n,
        (result_valid && result_ready) ##1
        (result_valid && result_ready && !result.prediction_correct) |->
        (result.correct_count == $past(result.correct_count)),
        "count moved on a wrong prediction")

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (.*);
